[sv/afnsm_pkg.sv]
// ----------------------------------------------------------------------------
// afnsm_pkg
// Shared widths, reset values, register indexes and types of the aspect-fit
// nearest-neighbor scaler address map.
// ----------------------------------------------------------------------------
package afnsm_pkg;

   // largest usable source image
   localparam int MAX_SRC_WIDTH  = 1920;
   localparam int MAX_SRC_HEIGHT = 1080;

   // field widths
   localparam int COORD_BITS    = 12;
   localparam int SRC_BITS      = 11;
   localparam int BOX_BITS      = 12;
   localparam int POS_BITS      = 13;
   localparam int SCR_BITS      = 14;
   localparam int IDX_BITS      = 21;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 13;

   // coordinate times source size, and the quotient bits left after the clamp
   localparam int PROD_BITS  = COORD_BITS + SRC_BITS;
   localparam int QUO_BITS   = SRC_BITS;
   localparam int DIV_STAGES = QUO_BITS;

   // register reset values
   localparam logic [SRC_BITS-1:0] RST_SOURCE_WIDTH  = 11'd1;
   localparam logic [SRC_BITS-1:0] RST_SOURCE_HEIGHT = 11'd1;
   localparam logic [POS_BITS-1:0] RST_BOX_LEFT      = 13'd0;
   localparam logic [POS_BITS-1:0] RST_BOX_TOP       = 13'd0;
   localparam logic [BOX_BITS-1:0] RST_BOX_WIDTH     = 12'd608;
   localparam logic [BOX_BITS-1:0] RST_BOX_HEIGHT    = 12'd400;

   // register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_SOURCE_WIDTH  = 3'd0,
      REG_SOURCE_HEIGHT = 3'd1,
      REG_BOX_LEFT      = 3'd2,
      REG_BOX_TOP       = 3'd3,
      REG_BOX_WIDTH     = 3'd4,
      REG_BOX_HEIGHT    = 3'd5
   } reg_idx_type;

   // configuration register file
   typedef struct packed {
      logic [SRC_BITS-1:0] source_width;
      logic [SRC_BITS-1:0] source_height;
      logic [POS_BITS-1:0] box_left;
      logic [POS_BITS-1:0] box_top;
      logic [BOX_BITS-1:0] box_width;
      logic [BOX_BITS-1:0] box_height;
   } cfg_type;

   // fitted rectangle, derived from the configuration
   typedef struct packed {
      logic                src_ok;
      logic [BOX_BITS-1:0] fit_w;
      logic [BOX_BITS-1:0] fit_h;
      logic [SCR_BITS-1:0] base_x;
      logic [SCR_BITS-1:0] base_y;
   } fit_type;

endpackage

[sv/afnsm_if.sv]
// ----------------------------------------------------------------------------
// afnsm channel interfaces
// Valid/ready channels for destination pixels, mapped results and register
// writes.
// ----------------------------------------------------------------------------

// destination pixel channel
interface afnsm_req_if;
   logic                             valid;
   logic                             ready;
   logic [afnsm_pkg::COORD_BITS-1:0] dest_col;
   logic [afnsm_pkg::COORD_BITS-1:0] dest_row;

   modport source (output valid, dest_col, dest_row, input ready);
   modport sink   (input valid, dest_col, dest_row, output ready);
endinterface

// mapped result channel
interface afnsm_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  inside_res;
   logic        [afnsm_pkg::SRC_BITS-1:0] src_col;
   logic        [afnsm_pkg::SRC_BITS-1:0] src_row;
   logic        [afnsm_pkg::IDX_BITS-1:0] src_index;
   logic signed [afnsm_pkg::SCR_BITS-1:0] screen_x;
   logic signed [afnsm_pkg::SCR_BITS-1:0] screen_y;
   logic        [afnsm_pkg::BOX_BITS-1:0] fit_width;
   logic        [afnsm_pkg::BOX_BITS-1:0] fit_height;

   modport source (output valid, inside_res, src_col, src_row, src_index, screen_x,
                   screen_y, fit_width, fit_height, input ready);
   modport sink   (input valid, inside_res, src_col, src_row, src_index, screen_x,
                   screen_y, fit_width, fit_height, output ready);
endinterface

// register write channel
interface afnsm_csr_if;
   logic                                valid;
   logic                                ready;
   logic [afnsm_pkg::CSR_IDX_BITS-1:0]  index;
   logic [afnsm_pkg::CSR_DATA_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[sv/afnsm_div.sv]
// ----------------------------------------------------------------------------
// afnsm_div
// Pipelined restoring divider, one quotient bit per stage. The dividend is
// known to give a quotient below 2**QUO_BITS, so only those bits are formed.
// ----------------------------------------------------------------------------
module afnsm_div (
   input  logic                             clock,
   input  logic [afnsm_pkg::DIV_STAGES-1:0] en,
   input  logic [afnsm_pkg::PROD_BITS-1:0]  dividend,
   input  logic [afnsm_pkg::BOX_BITS-1:0]   divisor,
   output logic [afnsm_pkg::QUO_BITS-1:0]   quotient
);

   localparam int NS  = afnsm_pkg::DIV_STAGES;
   localparam int QB  = afnsm_pkg::QUO_BITS;
   localparam int RB  = afnsm_pkg::BOX_BITS;
   localparam int PB  = afnsm_pkg::PROD_BITS;

   // per stage: partial remainder and dividend bits turning into quotient bits
   logic [RB-1:0] rem_ff [NS];
   logic [QB-1:0] low_ff [NS];
   logic [RB-1:0] rem_src [NS];
   logic [QB-1:0] low_src [NS];
   logic [RB-1:0] rem_in [NS];
   logic [QB-1:0] low_in [NS];
   logic [RB:0]   trial [NS];
   logic [RB:0]   diff [NS];
   logic          ge [NS];

   // stage sources
   always_comb begin
      rem_src[0] = dividend[PB-1:QB];
      low_src[0] = dividend[QB-1:0];
      for (int k = 1; k < NS; k++) begin
         rem_src[k] = rem_ff[k-1];
         low_src[k] = low_ff[k-1];
      end
   end

   // one shift, compare and subtract per stage
   always_comb begin
      for (int k = 0; k < NS; k++) begin
         trial[k]  = {rem_src[k], low_src[k][QB-1]};
         diff[k]   = trial[k] - {1'b0, divisor};
         ge[k]     = trial[k] >= {1'b0, divisor};
         rem_in[k] = ge[k] ? diff[k][RB-1:0] : trial[k][RB-1:0];
         low_in[k] = {low_src[k][QB-2:0], ge[k]};
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (en[k]) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
         end
      end
   end

   assign quotient = low_ff[NS-1];

endmodule

[sv/afnsm_fit.sv]
// ----------------------------------------------------------------------------
// afnsm_fit
// Sequencer that fits the source image into the target box: one bit-serial
// division (two when the box caps the height), clamping and centering. Reruns
// after reset and every register write; fit_ready is low while it works.
// ----------------------------------------------------------------------------
module afnsm_fit (
   input  logic                clock,
   input  logic                reset,
   input  logic                restart,
   input  afnsm_pkg::cfg_type  cfg,
   output afnsm_pkg::fit_type  fit,
   output logic                fit_ready
);

   localparam int SB       = afnsm_pkg::SRC_BITS;
   localparam int BB       = afnsm_pkg::BOX_BITS;
   localparam int NB       = afnsm_pkg::SRC_BITS + afnsm_pkg::BOX_BITS;
   localparam int CB       = $clog2(NB);
   localparam int XB       = afnsm_pkg::SCR_BITS;

   typedef enum logic [5:0] {
      ST_MUL1 = 6'b000001,
      ST_DIV1 = 6'b000010,
      ST_CHK  = 6'b000100,
      ST_DIV2 = 6'b001000,
      ST_FIN  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [NB-1:0]      num_ff;
   logic [NB-1:0]      num_in;
   logic [SB-1:0]      rem_ff;
   logic [SB-1:0]      rem_in;
   logic [SB-1:0]      den_ff;
   logic [CB-1:0]      cnt_ff;
   logic [BB-1:0]      fw_ff;
   logic [BB-1:0]      fh_ff;
   afnsm_pkg::fit_type fit_ff;
   afnsm_pkg::fit_type fit_in;

   logic [SB:0]        trial;
   logic [SB:0]        diff;
   logic               ge;
   logic               last;
   logic               over;
   logic [BB-1:0]      fw1;
   logic [BB-1:0]      fh1;
   logic [BB-1:0]      gap_x;
   logic [BB-1:0]      gap_y;
   logic [BB-1:0]      off_x;
   logic [BB-1:0]      off_y;

   // one restoring division step
   always_comb begin
      trial  = {rem_ff, num_ff[NB-1]};
      diff   = trial - {1'b0, den_ff};
      ge     = trial >= {1'b0, den_ff};
      rem_in = ge ? diff[SB-1:0] : trial[SB-1:0];
      num_in = {num_ff[NB-2:0], ge};
      last   = cnt_ff == CB'(NB - 1);
      over   = num_ff > {{(NB-BB){1'b0}}, cfg.box_height};
   end

   // clamp to one, center in the box, check the source size
   always_comb begin
      fw1    = (fw_ff == '0) ? BB'(1) : fw_ff;
      fh1    = (fh_ff == '0) ? BB'(1) : fh_ff;
      gap_x  = cfg.box_width - fw1;
      gap_y  = cfg.box_height - fh1;
      off_x  = (fw1 >= cfg.box_width) ? '0 : (gap_x >> 1);
      off_y  = (fh1 >= cfg.box_height) ? '0 : (gap_y >> 1);
      fit_in.src_ok = (cfg.source_width != '0) && (cfg.source_height != '0)
                      && (32'(cfg.source_width) <= afnsm_pkg::MAX_SRC_WIDTH)
                      && (32'(cfg.source_height) <= afnsm_pkg::MAX_SRC_HEIGHT);
      fit_in.fit_w  = fw1;
      fit_in.fit_h  = fh1;
      fit_in.base_x = {cfg.box_left[afnsm_pkg::POS_BITS-1], cfg.box_left}
                      + {{(XB-BB){1'b0}}, off_x};
      fit_in.base_y = {cfg.box_top[afnsm_pkg::POS_BITS-1], cfg.box_top}
                      + {{(XB-BB){1'b0}}, off_y};
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_MUL1: state_in = ST_DIV1;
         ST_DIV1: if (last) state_in = ST_CHK;
         ST_CHK:  state_in = over ? ST_DIV2 : ST_FIN;
         ST_DIV2: if (last) state_in = ST_FIN;
         ST_FIN:  state_in = ST_DONE;
         ST_DONE: state_in = ST_DONE;
         default: state_in = ST_MUL1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff <= ST_MUL1;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath: height from box width; if too tall, width from box height
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_MUL1: begin
            num_ff <= {{BB{1'b0}}, cfg.source_height} * {{SB{1'b0}}, cfg.box_width};
            den_ff <= cfg.source_width;
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         ST_DIV1: begin
            num_ff <= num_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + CB'(1);
         end
         ST_CHK: begin
            if (over) begin
               fh_ff  <= cfg.box_height;
               num_ff <= {{BB{1'b0}}, cfg.source_width} * {{SB{1'b0}}, cfg.box_height};
               den_ff <= cfg.source_height;
               rem_ff <= '0;
               cnt_ff <= '0;
            end else begin
               fh_ff <= num_ff[BB-1:0];
               fw_ff <= cfg.box_width;
            end
         end
         ST_DIV2: begin
            num_ff <= num_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + CB'(1);
            if (last) fw_ff <= num_in[BB-1:0];
         end
         ST_FIN: begin
            fit_ff <= fit_in;
         end
         ST_DONE: begin
            fit_ff <= fit_ff;
         end
         default: begin
            cnt_ff <= '0;
         end
      endcase
   end

   assign fit       = fit_ff;
   assign fit_ready = (state_ff == ST_DONE);

endmodule

[sv/aspect_fit_nearest_scaler_map_core.sv]
// ----------------------------------------------------------------------------
// aspect_fit_nearest_scaler_map_core
// Maps destination pixels of an aspect-preserving, centered nearest-neighbor
// blit to source pixel addresses and screen positions.
// ----------------------------------------------------------------------------
// Usage
//   csr_ch : register writes (index, data); always ready. Registers are to be
//            written only while no pixel is in flight; the block does not enforce it.
//   req_ch : one destination column/row per transaction.
//   rsp_ch : one mapped result per request, in request order.
// After reset and after every register write the fit sequencer recomputes
// the fitted rectangle with one bit-serial division, or two when the height
// is capped by the box, and req_ch.ready stays low meanwhile.
// Throughput is one pixel per cycle while rsp_ch is ready and the fit is done.
// A request passes one input stage, one multiply stage, eleven divider
// stages (one quotient bit each, column and row side by side), one clamp and
// index multiply stage and the output register.
// When rsp_ch stalls, the pipeline stops from the back and fills its empty
// stages; requests are taken as long as some stage is free and the fit is done.
// Reset is synchronous and active high; it clears the registers to their
// defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module aspect_fit_nearest_scaler_map_core (
   input  logic        clock,
   input  logic        reset,
   afnsm_req_if.sink   req_ch,
   afnsm_rsp_if.source rsp_ch,
   afnsm_csr_if.sink   csr_ch
);

   localparam int NS   = afnsm_pkg::DIV_STAGES;
   localparam int LAST = NS + 3;
   localparam int CB   = afnsm_pkg::COORD_BITS;
   localparam int SB   = afnsm_pkg::SRC_BITS;
   localparam int BB   = afnsm_pkg::BOX_BITS;
   localparam int PB   = afnsm_pkg::PROD_BITS;
   localparam int XB   = afnsm_pkg::SCR_BITS;
   localparam int IB   = afnsm_pkg::IDX_BITS;

   typedef struct packed {
      logic          ins;
      logic          col_ge;
      logic          row_ge;
      logic [XB-1:0] scr_x;
      logic [XB-1:0] scr_y;
   } side_type;

   afnsm_pkg::cfg_type cfg_ff;
   afnsm_pkg::fit_type fit;
   logic               fit_ready;
   logic               csr_acc;
   logic               req_acc;

   logic [LAST:0]      v_ff;
   logic [LAST:0]      v_prev;
   logic [LAST:0]      en;
   logic               full;

   logic [CB-1:0]      col0_ff;
   logic [CB-1:0]      row0_ff;
   logic [PB-1:0]      numc1_ff;
   logic [PB-1:0]      numr1_ff;
   side_type           side1_ff;
   side_type           side1_in;
   side_type           side_d_ff [NS];
   logic [SB-1:0]      qc;
   logic [SB-1:0]      qr;

   logic [SB-1:0]      sx_in;
   logic [SB-1:0]      sy_in;
   logic [SB-1:0]      sx_m_ff;
   logic [2*SB-1:0]    prod_m_ff;
   logic               ins_m_ff;
   logic [XB-1:0]      scrx_m_ff;
   logic [XB-1:0]      scry_m_ff;
   logic [SB-1:0]      sy_m_ff;
   logic [2*SB-1:0]    idx_sum;

   logic               ins_o_ff;
   logic [SB-1:0]      sx_o_ff;
   logic [SB-1:0]      sy_o_ff;
   logic [IB-1:0]      idx_o_ff;
   logic [XB-1:0]      scrx_o_ff;
   logic [XB-1:0]      scry_o_ff;
   logic [BB-1:0]      fw_o_ff;
   logic [BB-1:0]      fh_o_ff;

   // register writes
   assign csr_ch.ready = 1'b1;
   assign csr_acc      = csr_ch.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width  <= afnsm_pkg::RST_SOURCE_WIDTH;
         cfg_ff.source_height <= afnsm_pkg::RST_SOURCE_HEIGHT;
         cfg_ff.box_left      <= afnsm_pkg::RST_BOX_LEFT;
         cfg_ff.box_top       <= afnsm_pkg::RST_BOX_TOP;
         cfg_ff.box_width     <= afnsm_pkg::RST_BOX_WIDTH;
         cfg_ff.box_height    <= afnsm_pkg::RST_BOX_HEIGHT;
      end else if (csr_acc) begin
         unique case (afnsm_pkg::reg_idx_type'(csr_ch.index))
            afnsm_pkg::REG_SOURCE_WIDTH:  cfg_ff.source_width  <= csr_ch.data[SB-1:0];
            afnsm_pkg::REG_SOURCE_HEIGHT: cfg_ff.source_height <= csr_ch.data[SB-1:0];
            afnsm_pkg::REG_BOX_LEFT:      cfg_ff.box_left      <= csr_ch.data;
            afnsm_pkg::REG_BOX_TOP:       cfg_ff.box_top       <= csr_ch.data;
            afnsm_pkg::REG_BOX_WIDTH:     cfg_ff.box_width     <= csr_ch.data[BB-1:0];
            afnsm_pkg::REG_BOX_HEIGHT:    cfg_ff.box_height    <= csr_ch.data[BB-1:0];
            default: ;
         endcase
      end
   end

   // fitted rectangle
   afnsm_fit u_fit (
      .clock     (clock),
      .reset     (reset),
      .restart   (csr_acc),
      .cfg       (cfg_ff),
      .fit       (fit),
      .fit_ready (fit_ready)
   );

   // stage k moves when some stage from k to the output is empty or the
   // output transaction completes
   always_comb begin
      full = 1'b1;
      for (int k = 0; k <= LAST; k++) begin
         full = 1'b1;
         for (int j = k; j <= LAST; j++) begin
            full = full & v_ff[j];
         end
         en[k] = rsp_ch.ready || !full;
      end
   end

   assign req_ch.ready = en[0] && fit_ready;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign v_prev       = {v_ff[LAST-1:0], req_acc};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (en & v_prev) | (~en & v_ff);
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (en[0]) begin
         col0_ff <= req_ch.dest_col;
         row0_ff <= req_ch.dest_row;
      end
   end

   // products, bounds and screen position
   always_comb begin
      side1_in.ins    = (col0_ff < fit.fit_w) && (row0_ff < fit.fit_h);
      side1_in.col_ge = !(col0_ff < fit.fit_w);
      side1_in.row_ge = !(row0_ff < fit.fit_h);
      side1_in.scr_x  = fit.base_x + {{(XB-CB){1'b0}}, col0_ff};
      side1_in.scr_y  = fit.base_y + {{(XB-CB){1'b0}}, row0_ff};
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         numc1_ff <= {{SB{1'b0}}, col0_ff} * {{CB{1'b0}}, cfg_ff.source_width};
         numr1_ff <= {{SB{1'b0}}, row0_ff} * {{CB{1'b0}}, cfg_ff.source_height};
         side1_ff <= side1_in;
      end
   end

   // column and row dividers
   afnsm_div u_div_col (
      .clock    (clock),
      .en       (en[NS+1:2]),
      .dividend (numc1_ff),
      .divisor  (fit.fit_w),
      .quotient (qc)
   );

   afnsm_div u_div_row (
      .clock    (clock),
      .en       (en[NS+1:2]),
      .dividend (numr1_ff),
      .divisor  (fit.fit_h),
      .quotient (qr)
   );

   // side data travelling beside the dividers
   always_ff @(posedge clock) begin
      if (en[2]) side_d_ff[0] <= side1_ff;
      for (int k = 1; k < NS; k++) begin
         if (en[k+2]) side_d_ff[k] <= side_d_ff[k-1];
      end
   end

   // clamp to the last source pixel, start the index multiply
   always_comb begin
      sx_in = side_d_ff[NS-1].col_ge ? (cfg_ff.source_width - SB'(1)) : qc;
      sy_in = side_d_ff[NS-1].row_ge ? (cfg_ff.source_height - SB'(1)) : qr;
   end

   always_ff @(posedge clock) begin
      if (en[LAST-1]) begin
         sx_m_ff   <= sx_in;
         sy_m_ff   <= sy_in;
         prod_m_ff <= {{SB{1'b0}}, sy_in} * {{SB{1'b0}}, cfg_ff.source_width};
         ins_m_ff  <= side_d_ff[NS-1].ins;
         scrx_m_ff <= side_d_ff[NS-1].scr_x;
         scry_m_ff <= side_d_ff[NS-1].scr_y;
      end
   end

   // output register; an unusable source size forces every field to zero
   assign idx_sum = prod_m_ff + {{SB{1'b0}}, sx_m_ff};

   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         ins_o_ff  <= fit.src_ok && ins_m_ff;
         sx_o_ff   <= fit.src_ok ? sx_m_ff : '0;
         sy_o_ff   <= fit.src_ok ? sy_m_ff : '0;
         idx_o_ff  <= fit.src_ok ? idx_sum[IB-1:0] : '0;
         scrx_o_ff <= fit.src_ok ? scrx_m_ff : '0;
         scry_o_ff <= fit.src_ok ? scry_m_ff : '0;
         fw_o_ff   <= fit.src_ok ? fit.fit_w : '0;
         fh_o_ff   <= fit.src_ok ? fit.fit_h : '0;
      end
   end

   assign rsp_ch.valid      = v_ff[LAST];
   assign rsp_ch.inside_res = ins_o_ff;
   assign rsp_ch.src_col    = sx_o_ff;
   assign rsp_ch.src_row    = sy_o_ff;
   assign rsp_ch.src_index  = idx_o_ff;
   assign rsp_ch.screen_x   = scrx_o_ff;
   assign rsp_ch.screen_y   = scry_o_ff;
   assign rsp_ch.fit_width  = fw_o_ff;
   assign rsp_ch.fit_height = fh_o_ff;

endmodule

[verif/tb_aspect_fit_nearest_scaler_map_core.sv]
// ----------------------------------------------------------------------------
// tb_aspect_fit_nearest_scaler_map_core
// Self-checking bench for the aspect-fit scaler address map. A local model
// of the fit and the nearest-neighbor mapping predicts every result. The
// bench runs directed corner cases and then random register settings and
// pixels, with random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_aspect_fit_nearest_scaler_map_core;

   localparam int LONG_HOLD = 300;
   localparam int DRAIN_CYCLES = 20;

   // widths used in size casts
   localparam int COORD_W = afnsm_pkg::COORD_BITS;
   localparam int DATA_W  = afnsm_pkg::CSR_DATA_BITS;
   localparam int IDX_W   = afnsm_pkg::IDX_BITS;

   // one mapped pixel as the block should return it
   typedef struct packed {
      logic                                in_rect;
      logic [afnsm_pkg::SRC_BITS-1:0]      src_col;
      logic [afnsm_pkg::SRC_BITS-1:0]      src_row;
      logic [afnsm_pkg::IDX_BITS-1:0]      src_index;
      logic [afnsm_pkg::SCR_BITS-1:0]      screen_x;
      logic [afnsm_pkg::SCR_BITS-1:0]      screen_y;
      logic [afnsm_pkg::BOX_BITS-1:0]      fit_width;
      logic [afnsm_pkg::BOX_BITS-1:0]      fit_height;
   } pixel_map_type;

   logic clock = 1'b0;
   logic reset;

   afnsm_req_if req_if ();
   afnsm_rsp_if rsp_if ();
   afnsm_csr_if csr_if ();

   afnsm_pkg::cfg_type regs;
   pixel_map_type      expected_maps[$];
   int                 fail_count = 0;
   bit                 idle_on = 1'b1;
   int                 long_holds_asked = 0;

   aspect_fit_nearest_scaler_map_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // fitted rectangle, source address and screen position of one pixel
   function automatic pixel_map_type map_pixel(input logic [COORD_W-1:0] col,
                                               input logic [COORD_W-1:0] row);
      pixel_map_type m;
      longint        sw, sh, bw, bh, fw, fh, sx, sy, ix, px, py, c, r, offx, offy;
      m = '0;
      sw = longint'(regs.source_width);
      sh = longint'(regs.source_height);
      bw = longint'(regs.box_width);
      bh = longint'(regs.box_height);
      c = longint'(col);
      r = longint'(row);
      // no image: everything reads as zero
      if (sw == 0 || sh == 0 || sw > afnsm_pkg::MAX_SRC_WIDTH
          || sh > afnsm_pkg::MAX_SRC_HEIGHT)
         return m;
      // width-first fit, capped by the box height
      fw = bw;
      fh = (sh * fw) / sw;
      if (fh > bh) begin
         fh = bh;
         fw = (sw * fh) / sh;
      end
      if (fw < 1) fw = 1;
      if (fh < 1) fh = 1;
      // nearest source pixel, clamped to the image
      sx = (c * sw) / fw;
      if (sx >= sw) sx = sw - 1;
      sy = (r * sh) / fh;
      if (sy >= sh) sy = sh - 1;
      ix = sy * sw + sx;
      // centering offset is zero when the fit overhangs the box
      offx = (fw >= bw) ? 0 : (bw - fw) / 2;
      offy = (fh >= bh) ? 0 : (bh - fh) / 2;
      px = longint'($signed(regs.box_left)) + offx + c;
      py = longint'($signed(regs.box_top)) + offy + r;
      m.in_rect    = (c < fw && r < fh);
      m.src_col    = sx[afnsm_pkg::SRC_BITS-1:0];
      m.src_row    = sy[afnsm_pkg::SRC_BITS-1:0];
      m.src_index  = ix[afnsm_pkg::IDX_BITS-1:0];
      m.screen_x   = px[afnsm_pkg::SCR_BITS-1:0];
      m.screen_y   = py[afnsm_pkg::SCR_BITS-1:0];
      m.fit_width  = fw[afnsm_pkg::BOX_BITS-1:0];
      m.fit_height = fh[afnsm_pkg::BOX_BITS-1:0];
      return m;
   endfunction

   function automatic void check_field(input string name, input logic [IDX_W-1:0] want,
                                       input logic [IDX_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      pixel_map_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_maps.size() == 0) begin
            fail_count++;
            $error("result transaction with no request outstanding");
         end else begin
            want = expected_maps.pop_front();
            check_field("inside_res", IDX_W'(want.in_rect), IDX_W'(rsp_if.inside_res));
            check_field("src_col", IDX_W'(want.src_col), IDX_W'(rsp_if.src_col));
            check_field("src_row", IDX_W'(want.src_row), IDX_W'(rsp_if.src_row));
            check_field("src_index", want.src_index, rsp_if.src_index);
            check_field("screen_x", IDX_W'(want.screen_x),
                        IDX_W'($unsigned(rsp_if.screen_x)));
            check_field("screen_y", IDX_W'(want.screen_y),
                        IDX_W'($unsigned(rsp_if.screen_y)));
            check_field("fit_width", IDX_W'(want.fit_width), IDX_W'(rsp_if.fit_width));
            check_field("fit_height", IDX_W'(want.fit_height), IDX_W'(rsp_if.fit_height));
         end
      end
   end

   // result ready: random stall bursts, plus the long hold-off on request
   initial begin : rsp_sink
      int stall;
      int holds_done;
      holds_done = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         stall = 0;
         if (long_holds_asked != holds_done) begin
            holds_done = long_holds_asked;
            stall = LONG_HOLD;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 11);
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   // one request transaction; valid stays high for a following pixel
   task automatic send_pixel(input logic [COORD_W-1:0] col,
                             input logic [COORD_W-1:0] row);
      pixel_map_type want;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      want = map_pixel(col, row);
      req_if.valid    <= 1'b1;
      req_if.dest_col <= col;
      req_if.dest_row <= row;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      expected_maps.push_back(want);
   endtask

   // stop requesting and let every outstanding result come back
   task automatic wait_results_done();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (expected_maps.size() != 0);
   endtask

   task automatic write_reg(input afnsm_pkg::reg_idx_type idx,
                            input logic [DATA_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      case (idx)
         afnsm_pkg::REG_SOURCE_WIDTH:
            regs.source_width  = value[afnsm_pkg::SRC_BITS-1:0];
         afnsm_pkg::REG_SOURCE_HEIGHT:
            regs.source_height = value[afnsm_pkg::SRC_BITS-1:0];
         afnsm_pkg::REG_BOX_LEFT:
            regs.box_left      = value[afnsm_pkg::POS_BITS-1:0];
         afnsm_pkg::REG_BOX_TOP:
            regs.box_top       = value[afnsm_pkg::POS_BITS-1:0];
         afnsm_pkg::REG_BOX_WIDTH:
            regs.box_width     = value[afnsm_pkg::BOX_BITS-1:0];
         afnsm_pkg::REG_BOX_HEIGHT:
            regs.box_height    = value[afnsm_pkg::BOX_BITS-1:0];
         default: ;
      endcase
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // program a full setting once the pipeline is empty
   task automatic set_config(input int sw, input int sh, input int left, input int top,
                             input int bw, input int bh);
      wait_results_done();
      write_reg(afnsm_pkg::REG_SOURCE_WIDTH, DATA_W'(sw));
      write_reg(afnsm_pkg::REG_SOURCE_HEIGHT, DATA_W'(sh));
      write_reg(afnsm_pkg::REG_BOX_LEFT, DATA_W'(left));
      write_reg(afnsm_pkg::REG_BOX_TOP, DATA_W'(top));
      write_reg(afnsm_pkg::REG_BOX_WIDTH, DATA_W'(bw));
      write_reg(afnsm_pkg::REG_BOX_HEIGHT, DATA_W'(bh));
   endtask

   task automatic random_config();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 6)
         set_config($urandom_range(1, afnsm_pkg::MAX_SRC_WIDTH),
                    $urandom_range(1, afnsm_pkg::MAX_SRC_HEIGHT),
                    int'($urandom_range(0, 6143)) - 2048, int'($urandom_range(0, 6143)) - 2048,
                    $urandom_range(1, 4095), $urandom_range(1, 4095));
      else if (kind < 9)
         set_config($urandom_range(1, 16), $urandom_range(1, 16),
                    int'($urandom_range(0, 6143)) - 2048, int'($urandom_range(0, 6143)) - 2048,
                    $urandom_range(1, 64), $urandom_range(1, 64));
      else
         // raw register words: unusable sizes and zero boxes can show up
         set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   // mostly inside the fitted span, some on its edge, some anywhere
   function automatic logic [COORD_W-1:0] pick_coord(input int span);
      int mode;
      int v;
      mode = $urandom_range(0, 19);
      if (mode < 14) begin
         v = $urandom_range(0, span - 1);
      end else if (mode < 17) begin
         v = span - 1 + $urandom_range(0, 2);
         if (v > 4095) v = 4095;
      end else begin
         v = $urandom;
      end
      return COORD_W'(v);
   endfunction

   task automatic send_random_pixel();
      pixel_map_type probe;
      int            fw, fh;
      probe = map_pixel('0, '0);
      fw = (probe.fit_width == 0) ? 4096 : int'(probe.fit_width);
      fh = (probe.fit_height == 0) ? 4096 : int'(probe.fit_height);
      send_pixel(pick_coord(fw), pick_coord(fh));
   endtask

   // reset values: 1x1 source fitted into a 608x400 box
   task automatic test_reset_defaults();
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd399, 12'd399);
      send_pixel(12'd400, 12'd4095);
   endtask

   // full-size source in the default box, corners and just outside
   task automatic test_corners();
      set_config(afnsm_pkg::MAX_SRC_WIDTH, afnsm_pkg::MAX_SRC_HEIGHT, -2048, 4095, 608, 400);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd607, 12'd341);
      send_pixel(12'd608, 12'd0);
      send_pixel(12'd0, 12'd342);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd1365, 12'd2730);
   endtask

   // zero or oversized source dimensions give an all-zero result
   task automatic test_unusable_source();
      set_config(0, 100, 5, 5, 200, 200);
      send_pixel(12'd3, 12'd3);
      set_config(afnsm_pkg::MAX_SRC_WIDTH + 1, 100, 5, 5, 200, 200);
      send_pixel(12'd3, 12'd3);
      set_config(100, afnsm_pkg::MAX_SRC_HEIGHT + 1, 5, 5, 200, 200);
      send_pixel(12'd3, 12'd3);
      set_config(2047, 0, 5, 5, 200, 200);
      send_pixel(12'd3, 12'd3);
   endtask

   // zero box sizes clamp the fit to 1 and drop the centering offset on a zero side
   task automatic test_zero_box();
      set_config(4, 3, 10, 20, 0, 0);
      send_pixel(12'd0, 12'd0);
      set_config(4, 3, 10, 20, 0, 100);
      send_pixel(12'd1, 12'd5);
      set_config(4, 3, 10, 20, 100, 0);
      send_pixel(12'd0, 12'd1);
   endtask

   // screen position wrapping past the top of its range, and a negative box corner
   task automatic test_screen_wrap();
      set_config(16, 9, 4095, 4095, 4095, 4095);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd2048, 12'd2302);
      set_config(1, 1, -2048, -2048, 1, 1);
      send_pixel(12'd0, 12'd0);
   endtask

   // hold the output off long enough for the pipeline to back up
   task automatic test_output_backpressure();
      random_config();
      idle_on = 1'b0;
      long_holds_asked <= long_holds_asked + 1;
      repeat (60) send_random_pixel();
      idle_on = 1'b1;
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < 11; p++) begin
         if (p == 0)
            set_config(afnsm_pkg::MAX_SRC_WIDTH, afnsm_pkg::MAX_SRC_HEIGHT, -2048, 4095,
                       4095, 4095);
         else if (p == 1)
            set_config(1, afnsm_pkg::MAX_SRC_HEIGHT, 4095, -2048, 4095, 1);
         else if (p == 2)
            set_config(afnsm_pkg::MAX_SRC_WIDTH, 1, 0, 0, 1, 4095);
         else
            random_config();
         idle_on = (p % 3 != 2);
         repeat (110) send_random_pixel();
      end
   endtask

   // last stretch runs at full rate on both sides
   task automatic test_full_rate_tail();
      random_config();
      idle_on = 1'b0;
      repeat (80) send_random_pixel();
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.dest_col = '0;
      req_if.dest_row = '0;
      csr_if.valid = 1'b0;
      csr_if.index = afnsm_pkg::REG_SOURCE_WIDTH;
      csr_if.data = '0;
      regs.source_width  = afnsm_pkg::RST_SOURCE_WIDTH;
      regs.source_height = afnsm_pkg::RST_SOURCE_HEIGHT;
      regs.box_left      = afnsm_pkg::RST_BOX_LEFT;
      regs.box_top       = afnsm_pkg::RST_BOX_TOP;
      regs.box_width     = afnsm_pkg::RST_BOX_WIDTH;
      regs.box_height    = afnsm_pkg::RST_BOX_HEIGHT;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_corners();
      test_unusable_source();
      test_zero_box();
      test_screen_wrap();
      test_output_backpressure();
      test_random_settings();
      test_full_rate_tail();

      wait_results_done();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_maps.size() == 0)
         $display("[aspect_fit_nearest_scaler_map_core] OK");
      else
         $display("[aspect_fit_nearest_scaler_map_core] ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("[aspect_fit_nearest_scaler_map_core] ERROR");
      $finish;
   end

endmodule

[aspect_fit_nearest_scaler_map_core.f]
sv/afnsm_pkg.sv
sv/afnsm_if.sv
sv/afnsm_div.sv
sv/afnsm_fit.sv
sv/aspect_fit_nearest_scaler_map_core.sv
verif/tb_aspect_fit_nearest_scaler_map_core.sv
